[design/ttuv_pkg.sv]
// ----------------------------------------------------------------------------
// ttuv_pkg: shared constants for the triangle tangent block
// Vertex phase codes and widths.
// ----------------------------------------------------------------------------
package ttuv_pkg;
	localparam int POS_WIDTH_DEF = 24;
	localparam int UV_WIDTH_DEF  = 16;
	localparam int OUT_W         = 32;
	localparam int OUT_FRAC      = 16;
	localparam int OUT_INT_LIMIT = 15;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;
endpackage

[design/ttuv_front.sv]
// ----------------------------------------------------------------------------
// ttuv_front: vertex intake
// Holds the first two vertices of a triangle; on the third forms the
// numerators and the determinant and pushes one request to the queue.
// ----------------------------------------------------------------------------
module ttuv_front import ttuv_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int UV_WIDTH  = UV_WIDTH_DEF,
	localparam int NW = POS_WIDTH + UV_WIDTH + 3,
	localparam int DW = 2 * UV_WIDTH + 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [POS_WIDTH-1:0] px,
	input  logic signed [POS_WIDTH-1:0] py,
	input  logic signed [POS_WIDTH-1:0] pz,
	input  logic signed [UV_WIDTH-1:0]  tu,
	input  logic signed [UV_WIDTH-1:0]  tv,
	output logic                        req_valid,
	input  logic                        req_ready,
	output logic signed [NW-1:0]        req_nx,
	output logic signed [NW-1:0]        req_ny,
	output logic signed [NW-1:0]        req_nz,
	output logic signed [DW-1:0]        req_det
);
	logic [1:0] phase_q;
	logic signed [POS_WIDTH-1:0] p0x_q, p0y_q, p0z_q, p1x_q, p1y_q, p1z_q;
	logic signed [UV_WIDTH-1:0]  u0_q, v0_q, u1_q, v1_q;
	logic signed [POS_WIDTH:0]   d1x_s1, d1y_s1, d1z_s1, d2x_s1, d2y_s1, d2z_s1;
	logic signed [UV_WIDTH:0]    du1_s1, dv1_s1, du2_s1, dv2_s1;
	logic                        v_s1;
	logic                        take;

	assign in_ready = !v_s1 || (!req_valid || req_ready);
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			v_s1 <= 1'b0;
			req_valid <= 1'b0;
		end else begin
			if (v_s1 && (!req_valid || req_ready)) begin
				req_valid <= 1'b1;
				v_s1 <= 1'b0;
			end else if (req_valid && req_ready) begin
				req_valid <= 1'b0;
			end
			if (take) begin
				case (phase_q)
					PH_SECOND: phase_q <= PH_THIRD;
					PH_THIRD: begin
						phase_q <= PH_FIRST;
						v_s1 <= 1'b1;
					end
					default: phase_q <= PH_SECOND;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && phase_q == PH_SECOND) begin
			p1x_q <= px; p1y_q <= py; p1z_q <= pz; u1_q <= tu; v1_q <= tv;
		end else if (take && phase_q != PH_THIRD) begin
			p0x_q <= px; p0y_q <= py; p0z_q <= pz; u0_q <= tu; v0_q <= tv;
		end
		if (take && phase_q == PH_THIRD) begin
			d1x_s1 <= (POS_WIDTH+1)'(p1x_q) - (POS_WIDTH+1)'(p0x_q);
			d1y_s1 <= (POS_WIDTH+1)'(p1y_q) - (POS_WIDTH+1)'(p0y_q);
			d1z_s1 <= (POS_WIDTH+1)'(p1z_q) - (POS_WIDTH+1)'(p0z_q);
			d2x_s1 <= (POS_WIDTH+1)'(px) - (POS_WIDTH+1)'(p0x_q);
			d2y_s1 <= (POS_WIDTH+1)'(py) - (POS_WIDTH+1)'(p0y_q);
			d2z_s1 <= (POS_WIDTH+1)'(pz) - (POS_WIDTH+1)'(p0z_q);
			du1_s1 <= (UV_WIDTH+1)'(u1_q) - (UV_WIDTH+1)'(u0_q);
			dv1_s1 <= (UV_WIDTH+1)'(v1_q) - (UV_WIDTH+1)'(v0_q);
			du2_s1 <= (UV_WIDTH+1)'(tu) - (UV_WIDTH+1)'(u0_q);
			dv2_s1 <= (UV_WIDTH+1)'(tv) - (UV_WIDTH+1)'(v0_q);
		end
		if (v_s1 && (!req_valid || req_ready)) begin
			req_nx  <= NW'(d1x_s1) * NW'(dv2_s1) - NW'(d2x_s1) * NW'(dv1_s1);
			req_ny  <= NW'(d1y_s1) * NW'(dv2_s1) - NW'(d2y_s1) * NW'(dv1_s1);
			req_nz  <= NW'(d1z_s1) * NW'(dv2_s1) - NW'(d2z_s1) * NW'(dv1_s1);
			req_det <= DW'(du1_s1) * DW'(dv2_s1) - DW'(dv1_s1) * DW'(du2_s1);
		end
	end

	ap_ph: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIRST || phase_q == PH_SECOND || phase_q == PH_THIRD)
		else $error("phase out of range");
	ap_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_THIRD |=> v_s1)
		else $error("third vertex lost");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req_det))
		else $error("request dropped");
endmodule

[design/ttuv_back.sv]
// ----------------------------------------------------------------------------
// ttuv_back: tangent divider
// Restoring division, one quotient bit per cycle, shared over x, y and z.
// ----------------------------------------------------------------------------
module ttuv_back import ttuv_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int UV_WIDTH  = UV_WIDTH_DEF,
	localparam int NW = POS_WIDTH + UV_WIDTH + 3,
	localparam int DW = 2 * UV_WIDTH + 3,
	localparam int QW = NW + OUT_FRAC,
	localparam int CW = $clog2(QW + 2)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic signed [NW-1:0] req_nx,
	input  logic signed [NW-1:0] req_ny,
	input  logic signed [NW-1:0] req_nz,
	input  logic signed [DW-1:0] req_det,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3*OUT_W:0]     out_data
);
	logic              busy_q;
	logic [1:0]        axis_q;
	logic [CW-1:0]     cnt_q;
	logic signed [NW-1:0] n_q [3];
	logic [DW-1:0]     den_q;
	logic              dneg_q;
	logic [QW-1:0]     quo_q;
	logic [DW:0]       rem_q;
	logic              nneg_q;
	logic [OUT_W-1:0]  t_q [3];
	logic              degen_q;
	logic [DW:0]       trial;
	logic [OUT_W-1:0]  mag, res;
	logic              ovf;
	logic [NW-1:0]     un;

	assign req_ready = !busy_q && !out_valid;
	assign trial = {rem_q[DW-1:0], quo_q[QW-1]};
	assign ovf = |quo_q[QW-1:OUT_FRAC+OUT_INT_LIMIT];
	assign mag = quo_q[OUT_W-1:0];
	assign res = ovf ? (nneg_q != dneg_q ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}})
		: (nneg_q != dneg_q ? OUT_W'(0) - mag : mag);
	assign un = n_q[axis_q][NW-1] ? NW'(0) - n_q[axis_q] : n_q[axis_q];
	assign out_data = {degen_q, t_q[2], t_q[1], t_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
			cnt_q <= '0;
			axis_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (req_valid && req_ready) begin
				busy_q <= req_det != '0;
				out_valid <= req_det == '0;
				axis_q <= '0;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(QW + 1)) begin
					cnt_q <= '0;
					if (axis_q == 2'd2) begin
						busy_q <= 1'b0;
						out_valid <= 1'b1;
					end else axis_q <= axis_q + 2'd1;
				end else cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			n_q[0] <= req_nx; n_q[1] <= req_ny; n_q[2] <= req_nz;
			dneg_q <= req_det[DW-1];
			den_q <= req_det[DW-1] ? DW'(0) - req_det : req_det;
			degen_q <= req_det == '0;
			for (int i = 0; i < 3; i++) t_q[i] <= '0;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				// load magnitude, scaled by 2^16
				quo_q <= {un, {OUT_FRAC{1'b0}}};
				rem_q <= '0;
				nneg_q <= n_q[axis_q][NW-1];
			end else if (cnt_q == CW'(QW + 1)) begin
				t_q[axis_q] <= res;
			end else begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
			end
		end
	end

	ap_deg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[3*OUT_W] |-> out_data[3*OUT_W-1:0] == '0)
		else $error("degenerate tangent not zero");
	ap_ex: assert property (@(posedge clk) disable iff (!arst_n) !(busy_q && out_valid))
		else $error("busy with result pending");
	ap_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
endmodule

[design/triangle_tangent_from_uv.sv]
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv: per-triangle tangent from texture coordinates
// Channel   Dir  Payload
// s_axis    in   tdata: vertex position xyz Q12.12, uv Q4.12
// m_axis    out  tdata: tangent xyz Q16.16 saturated; tuser: degenerate flag
// Vertices one and two are held in registers. The third starts the divider,
// which forms QW = POS_WIDTH+UV_WIDTH+19 quotient bits per axis with one radix-2
// divider shared over the three axes. A zero determinant skips it.
// arst_n clears phase and valid flags. A one-entry request register lets
// intake continue while the divider or the output stalls.
// ----------------------------------------------------------------------------
module triangle_tangent_from_uv import ttuv_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int UV_WIDTH  = UV_WIDTH_DEF,
	localparam int IW = ((3 * POS_WIDTH + 2 * UV_WIDTH + 7) / 8) * 8,
	localparam int OW = ((3 * OUT_W + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [IW-1:0] s_axis_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [OW-1:0] m_axis_tdata,  // tangent_x, tangent_y, tangent_z
	output logic          m_axis_tuser   // degenerate
);
	localparam int NW = POS_WIDTH + UV_WIDTH + 3;
	localparam int DW = 2 * UV_WIDTH + 3;
	localparam int P = POS_WIDTH;
	localparam int U = UV_WIDTH;

	logic                 rq_valid, rq_ready;
	logic signed [NW-1:0] nx, ny, nz;
	logic signed [DW-1:0] det;
	logic [3*OUT_W:0]     res;

	ttuv_front #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.px(s_axis_tdata[P-1:0]), .py(s_axis_tdata[2*P-1:P]),
		.pz(s_axis_tdata[3*P-1:2*P]),
		.tu(s_axis_tdata[3*P+U-1:3*P]), .tv(s_axis_tdata[3*P+2*U-1:3*P+U]),
		.req_valid(rq_valid), .req_ready(rq_ready),
		.req_nx(nx), .req_ny(ny), .req_nz(nz), .req_det(det)
	);

	ttuv_back #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH)) u_back (
		.clk, .arst_n,
		.req_valid(rq_valid), .req_ready(rq_ready),
		.req_nx(nx), .req_ny(ny), .req_nz(nz), .req_det(det),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);

	assign m_axis_tdata = OW'(res[3*OUT_W-1:0]);
	assign m_axis_tuser = res[3*OUT_W];
endmodule
